[rtl/core/sthc_pkg.sv]
// ----------------------------------------------------------------------------
// sthc_pkg: shared definitions for the heat-map color block
// Widths, configuration register indexes, color band codes and the record
// that travels through the divider stages.
// ----------------------------------------------------------------------------
`default_nettype none

package sthc_pkg;

    localparam int VALUE_WIDTH = 24;
    localparam int COLOR_WIDTH = 8;
    localparam int STEP_WIDTH  = 23;

    localparam int CFG_DATA_WIDTH  = (VALUE_WIDTH > STEP_WIDTH) ? VALUE_WIDTH : STEP_WIDTH;
    localparam int CFG_INDEX_WIDTH = 1;

    // Signed width that holds both sample minus minimum and four band steps.
    localparam int CMP_WIDTH = (VALUE_WIDTH + 1 > STEP_WIDTH + 3) ?
                               VALUE_WIDTH + 1 : STEP_WIDTH + 3;
    // Width of the dividend offset times full-scale color.
    localparam int NUM_WIDTH = STEP_WIDTH + COLOR_WIDTH;

    // Stages ahead of the divider, then one divider stage per quotient bit,
    // then the color output stage.
    localparam int FRONT_STAGES = 3;
    localparam int PIPE_STAGES  = FRONT_STAGES + COLOR_WIDTH + 1;

    localparam logic [STEP_WIDTH-1:0] BAND_STEP_RESET = STEP_WIDTH'(4096);

    typedef logic [COLOR_WIDTH-1:0] color_t;
    localparam color_t COLOR_MAX = '1;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_RANGE_MIN = 1'b0,
        CFG_BAND_STEP = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        BAND_BLUE   = 2'd0,
        BAND_GREEN  = 2'd1,
        BAND_YELLOW = 2'd2,
        BAND_RED    = 2'd3
    } band_t;

    typedef struct packed {
        logic [NUM_WIDTH-1:0]  rem;
        color_t                quo;
        logic [STEP_WIDTH-1:0] step;
        band_t                 band;
        logic                  full;
        logic                  oor;
    } div_t;

endpackage

`default_nettype wire

[rtl/core/scalar_to_heatmap_color.sv]
// ----------------------------------------------------------------------------
// scalar_to_heatmap_color: four-band heat-map colormap
// Maps one signed Q12.12 sample per word to an RGB color on a black, blue,
// green, yellow, red ramp, with saturation and an out-of-range flag.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                                   Word
//   --------  --------------------------------------  -------------------------
//   input     s_valid / s_ready                       s_sample_value
//   output    m_valid / m_ready                       m_red_level, m_green_level,
//                                                     m_blue_level, m_out_of_range
//   config    cfg_wr_en, cfg_index, cfg_wr_data       range_min, band_step
//
// One word can enter every clock unless an output stall has backed up to
// the input. The pipeline has three front stages, one restoring-divider
// stage per quotient bit of the band fraction, and the output register.
// Reset (aresetn low, synchronous) empties the pipeline and loads range_min
// to zero and band_step to 4096 (1.0). Every stage holds its word while the
// stage after it is full and stalled, so bubbles are squeezed out and s_ready
// stays high as long as any stage downstream has room.
// ----------------------------------------------------------------------------
`default_nettype none

module scalar_to_heatmap_color
    import sthc_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,

    input  wire logic                       cfg_wr_en,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_wr_data,

    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [VALUE_WIDTH-1:0]     s_sample_value,

    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [COLOR_WIDTH-1:0]          m_red_level,
    output logic [COLOR_WIDTH-1:0]          m_green_level,
    output logic [COLOR_WIDTH-1:0]          m_blue_level,
    output logic                            m_out_of_range
);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [VALUE_WIDTH-1:0] range_min_reg;
    logic [STEP_WIDTH-1:0]  band_step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            range_min_reg <= '0;
            band_step_reg <= BAND_STEP_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_RANGE_MIN: range_min_reg <= cfg_wr_data[VALUE_WIDTH-1:0];
                CFG_BAND_STEP: band_step_reg <= cfg_wr_data[STEP_WIDTH-1:0];
                default:       ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. A stage loads when it is empty or when the
    // stage after it loads, so a stall only backs up as far as the first
    // bubble.
    // ------------------------------------------------------------------
    logic [PIPE_STAGES-1:0] valid_reg;
    logic [PIPE_STAGES-1:0] load;

    always_comb begin
        load[PIPE_STAGES-1] = !valid_reg[PIPE_STAGES-1] || m_ready;
        for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
            load[i] = !valid_reg[i] || load[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (load[0]) begin
                valid_reg[0] <= s_valid;
            end
            for (int i = 1; i < PIPE_STAGES; i++) begin
                if (load[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    assign s_ready = load[0];
    assign m_valid = valid_reg[PIPE_STAGES-1];

    // ------------------------------------------------------------------
    // Stage 1: offset from the scale minimum, effective step (a zero step
    // counts as one) and three steps.
    // ------------------------------------------------------------------
    logic signed [CMP_WIDTH-1:0]  diff_next;
    logic [STEP_WIDTH-1:0]        step_next;
    logic [STEP_WIDTH+1:0]        step3_next;
    logic signed [CMP_WIDTH-1:0]  diff_reg;
    logic [STEP_WIDTH-1:0]        step_reg;
    logic [STEP_WIDTH+1:0]        step3_reg;

    always_comb begin
        diff_next = $signed({{(CMP_WIDTH-VALUE_WIDTH){s_sample_value[VALUE_WIDTH-1]}},
                             s_sample_value})
                  - $signed({{(CMP_WIDTH-VALUE_WIDTH){range_min_reg[VALUE_WIDTH-1]}},
                             range_min_reg});
        step_next  = (band_step_reg == '0) ? STEP_WIDTH'(1) : band_step_reg;
        step3_next = {2'b00, step_next} + {1'b0, step_next, 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (load[0]) begin
            diff_reg  <= diff_next;
            step_reg  <= step_next;
            step3_reg <= step3_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: band select, offset inside the band, saturation flags.
    // A negative offset is forced to the band start; at or past four steps
    // the fraction is forced to full scale.
    // ------------------------------------------------------------------
    logic signed [CMP_WIDTH-1:0] step1_s;
    logic signed [CMP_WIDTH-1:0] step2_s;
    logic signed [CMP_WIDTH-1:0] step3_s;
    logic signed [CMP_WIDTH-1:0] step4_s;
    logic signed [CMP_WIDTH-1:0] base_s;
    logic signed [CMP_WIDTH-1:0] offs_s;
    logic                        neg;
    logic                        ge4;
    band_t                       band_next;
    logic [STEP_WIDTH-1:0]       offs_next;
    logic                        full_next;
    logic                        oor_next;

    band_t                       band2_reg;
    logic [STEP_WIDTH-1:0]       offs2_reg;
    logic [STEP_WIDTH-1:0]       step2_reg;
    logic                        full2_reg;
    logic                        oor2_reg;

    always_comb begin
        step1_s = $signed({{(CMP_WIDTH-STEP_WIDTH){1'b0}}, step_reg});
        step2_s = $signed({{(CMP_WIDTH-STEP_WIDTH-1){1'b0}}, step_reg, 1'b0});
        step3_s = $signed({{(CMP_WIDTH-STEP_WIDTH-2){1'b0}}, step3_reg});
        step4_s = $signed({{(CMP_WIDTH-STEP_WIDTH-2){1'b0}}, step_reg, 2'b00});
        neg     = diff_reg[CMP_WIDTH-1];
        ge4     = diff_reg >= step4_s;

        priority if (diff_reg < step1_s) begin
            band_next = BAND_BLUE;
            base_s    = '0;
        end else if (diff_reg < step2_s) begin
            band_next = BAND_GREEN;
            base_s    = step1_s;
        end else if (diff_reg < step3_s) begin
            band_next = BAND_YELLOW;
            base_s    = step2_s;
        end else begin
            band_next = BAND_RED;
            base_s    = step3_s;
        end

        offs_s    = diff_reg - base_s;
        offs_next = neg ? '0 : offs_s[STEP_WIDTH-1:0];
        full_next = ge4;
        oor_next  = neg || (ge4 && (diff_reg != step4_s));
    end

    always_ff @(posedge aclk) begin
        if (load[1]) begin
            band2_reg <= band_next;
            offs2_reg <= offs_next;
            step2_reg <= step_reg;
            full2_reg <= full_next;
            oor2_reg  <= oor_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: dividend = offset * full-scale color, as a shift and subtract.
    // This feeds the head of the divider chain.
    // ------------------------------------------------------------------
    div_t div_pipe_reg [0:COLOR_WIDTH];
    div_t div_head_next;

    always_comb begin
        div_head_next.rem  = {offs2_reg, {COLOR_WIDTH{1'b0}}}
                           - {{COLOR_WIDTH{1'b0}}, offs2_reg};
        div_head_next.quo  = '0;
        div_head_next.step = step2_reg;
        div_head_next.band = band2_reg;
        div_head_next.full = full2_reg;
        div_head_next.oor  = oor2_reg;
    end

    always_ff @(posedge aclk) begin
        if (load[2]) begin
            div_pipe_reg[0] <= div_head_next;
        end
    end

    // ------------------------------------------------------------------
    // Restoring divider, one quotient bit per stage, most significant first.
    // Below four steps, dividend < step * 2^COLOR_WIDTH and the quotient fits.
    // ------------------------------------------------------------------
    for (genvar j = 0; j < COLOR_WIDTH; j++) begin : g_div
        localparam int QBIT = COLOR_WIDTH - 1 - j;

        div_t                 stage_next;
        logic [NUM_WIDTH-1:0] divisor;
        logic [NUM_WIDTH:0]   trial;

        always_comb begin
            stage_next = div_pipe_reg[j];
            divisor    = {{COLOR_WIDTH{1'b0}}, div_pipe_reg[j].step} << QBIT;
            trial      = {1'b0, div_pipe_reg[j].rem} - {1'b0, divisor};
            if (!trial[NUM_WIDTH]) begin
                stage_next.rem       = trial[NUM_WIDTH-1:0];
                stage_next.quo[QBIT] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (load[FRONT_STAGES+j]) begin
                div_pipe_reg[j+1] <= stage_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: the fraction drives the ramping channel of the band.
    // ------------------------------------------------------------------
    color_t frac;
    color_t red_next;
    color_t green_next;
    color_t blue_next;
    color_t red_reg;
    color_t green_reg;
    color_t blue_reg;
    logic   oor_reg;

    always_comb begin
        frac = div_pipe_reg[COLOR_WIDTH].full ? COLOR_MAX : div_pipe_reg[COLOR_WIDTH].quo;
        unique case (div_pipe_reg[COLOR_WIDTH].band)
            BAND_BLUE: begin
                red_next   = '0;
                green_next = '0;
                blue_next  = frac;
            end
            BAND_GREEN: begin
                red_next   = '0;
                green_next = frac;
                blue_next  = COLOR_MAX - frac;
            end
            BAND_YELLOW: begin
                red_next   = frac;
                green_next = COLOR_MAX;
                blue_next  = '0;
            end
            BAND_RED: begin
                red_next   = COLOR_MAX;
                green_next = COLOR_MAX - frac;
                blue_next  = '0;
            end
            default: begin
                red_next   = '0;
                green_next = '0;
                blue_next  = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (load[PIPE_STAGES-1]) begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            oor_reg   <= div_pipe_reg[COLOR_WIDTH].oor;
        end
    end

    assign m_red_level    = red_reg;
    assign m_green_level  = green_reg;
    assign m_blue_level   = blue_reg;
    assign m_out_of_range = oor_reg;

endmodule

`default_nettype wire
